// ===== sv/assert_macros.svh =====
// Assertion macros for the windowed tag table checker.
// Included by the checker file only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high
`define WTTS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("windowed tag table: implication check failed");

// Next-cycle implication, disabled while rst is high
`define WTTS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("windowed tag table: next-cycle check failed");

`endif

// ===== sv/wtts_pkg.sv =====
// Shared types, widths and codes for the windowed tag table search block.
// No dependencies; imported by the controller, datapath, top level and checker.
`timescale 1ns / 1ps

package wtts_pkg;

   // Store depth (any value from 512 to 65536) and delete granule (power of two)
   localparam int DEPTH          = 4096;
   localparam int DELETE_GRANULE = 512;

   // Field widths
   localparam int OP_W   = 3;
   localparam int TEXT_W = 31;
   localparam int TAG_W  = 16;
   localparam int CNT_W  = 13;
   localparam int ST_W   = 3;

   // Derived widths
   localparam int SLOT_W = $clog2(DEPTH);
   localparam int SUM_W  = SLOT_W + 1;
   localparam int LEFT_W = $clog2(DEPTH + 1);
   localparam int WIDE_W = TEXT_W + 1;
   localparam int WRAP_W = $clog2(DEPTH + (1 << CNT_W));

   // Beat packing
   localparam int TAG_LSB    = TEXT_W;
   localparam int CNT_LSB    = TEXT_W + TAG_W;
   localparam int REQ_DATA_W = ((TEXT_W + TAG_W + CNT_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((TEXT_W + TAG_W + 7) / 8) * 8;

   // Configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TEXT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INITIAL_LOW = 2'd1;

   typedef enum logic [OP_W-1:0] {
      OP_GET       = 3'd0,
      OP_SET       = 3'd1,
      OP_FIND_NEXT = 3'd2,
      OP_FIND_PREV = 3'd3,
      OP_DELETE    = 3'd4
   } op_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK        = 3'd0,
      ST_WINDOW    = 3'd1,
      ST_CAPACITY  = 3'd2,
      ST_BAD_DEL   = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   // Source of the result payload
   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_TAG   = 2'd1,
      RES_FOUND = 2'd2
   } res_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        take_item;
      logic        clr_step;
      logic        decode;
      logic        setup;
      logic        scan;
      logic        access;
      logic        del_apply;
      logic        wrap_step;
      logic        base_load;
      logic        res_load;
      status_type  res_status;
      res_sel_type res_sel;
      logic        out_load;
   } wtts_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic   clr_last;
      op_type op;
      logic   below;
      logic   above;
      logic   cap_bad;
      logic   del_bad;
      logic   scan_idle;
      logic   hit;
      logic   wrap_ge;
      logic   out_free;
   } wtts_stat_type;

endpackage

// ===== sv/windowed_tag_table_search.sv =====
// Top level of the windowed tag table search block.
// Depends on wtts_pkg, wtts_ctrl and wtts_dpath.
`timescale 1ns / 1ps

// Maps item numbers in the window [low, high_text] to 16-bit signed tags
// held in a circular store of DEPTH (4096) slots. One request is in work
// at a time; the response sits in an output register, so the next request
// is taken while it waits. After reset a clearing pass writes every slot
// to zero, one slot a cycle, so req_tready stays low until it is done;
// configuration writes are taken throughout. Each request passes the
// decode state; set, out-of-window and capacity failures then the access
// state, get the access and read states, delete the delete state and,
// unless the count is bad, one wrap step for each DEPTH the new base
// passes (up to 2 at the default sizes), and find_next and find_prev the
// setup state and a scan of the stored entries in range (up to DEPTH),
// one read a cycle on the single store read port, until a match or the end.
// req_tuser: op[2:0].
// req_tdata: text_number[30:0], tag[46:31], delete_count[59:47], zero fill.
// rsp_tuser: status[2:0].
// rsp_tdata: found_number[30:0], tag_out[46:31].
// csr_index 0 writes high_text, 1 writes initial_low_text (reloads low).

module windowed_tag_table_search (
   input  logic                              clock,
   input  logic                              reset,
   // request beats
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [wtts_pkg::OP_W-1:0]         req_tuser,   // op
   input  logic [wtts_pkg::REQ_DATA_W-1:0]   req_tdata,   // text_number, tag, delete_count
   // response beats
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [wtts_pkg::ST_W-1:0]         rsp_tuser,   // status
   output logic [wtts_pkg::RSP_DATA_W-1:0]   rsp_tdata,   // found_number, tag_out
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [wtts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wtts_pkg::TEXT_W-1:0]       csr_data
);
   import wtts_pkg::*;

   wtts_cmd_type  cmd;
   wtts_stat_type stat;

   // Configuration writes are always taken
   assign csr_ready = 1'b1;

   wtts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   wtts_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sv/wtts_ctrl.sv =====
// Sequencing state machine of the windowed tag table search block.
// Depends on wtts_pkg; drives the datapath through wtts_cmd_type.
`timescale 1ns / 1ps

module wtts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  wtts_pkg::wtts_stat_type stat,
   output wtts_pkg::wtts_cmd_type  cmd
);
   import wtts_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_ACCESS,
      S_READ,
      S_SETUP,
      S_SCAN,
      S_DELETE,
      S_WRAP,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   // Take a beat only when no item is in flight
   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_status = ST_OK;
      cmd.res_sel    = RES_NONE;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take_item = 1'b1;
               state_in      = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            case (stat.op)
               OP_GET, OP_SET: begin
                  state_in = S_ACCESS;
               end
               OP_FIND_NEXT, OP_FIND_PREV: begin
                  state_in = S_SETUP;
               end
               OP_DELETE: begin
                  state_in = S_DELETE;
               end
               default: begin
                  // unused code: plain ok, no state change
                  cmd.res_load = 1'b1;
                  state_in     = S_DONE;
               end
            endcase
         end
         S_ACCESS: begin
            if (stat.below || stat.above) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_WINDOW;
               state_in       = S_DONE;
            end else if (stat.cap_bad) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_CAPACITY;
               state_in       = S_DONE;
            end else begin
               cmd.access = 1'b1;
               if (stat.op == OP_SET) begin
                  cmd.res_load = 1'b1;
                  state_in     = S_DONE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_sel  = RES_TAG;
            state_in     = S_DONE;
         end
         S_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.hit) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FOUND;
               state_in     = S_DONE;
            end else if (stat.scan_idle) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_DELETE: begin
            if (stat.del_bad) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_BAD_DEL;
               state_in       = S_DONE;
            end else begin
               cmd.del_apply = 1'b1;
               state_in      = S_WRAP;
            end
         end
         S_WRAP: begin
            if (stat.wrap_ge) begin
               cmd.wrap_step = 1'b1;
            end else begin
               cmd.base_load = 1'b1;
               cmd.res_load  = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            // hold until the output register is free
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/wtts_dpath.sv =====
// Datapath of the windowed tag table search: window registers, tag store,
// scan pointer and result/output registers. Depends on wtts_pkg.
`timescale 1ns / 1ps

module wtts_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  wtts_pkg::wtts_cmd_type            cmd,
   output wtts_pkg::wtts_stat_type           stat,
   input  logic [wtts_pkg::OP_W-1:0]         req_tuser,
   input  logic [wtts_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic                              csr_valid,
   input  logic [wtts_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [wtts_pkg::TEXT_W-1:0]       csr_data,
   input  logic                              rsp_tready,
   output logic                              rsp_tvalid,
   output logic [wtts_pkg::ST_W-1:0]         rsp_tuser,
   output logic [wtts_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import wtts_pkg::*;

   // Circular slot of a window position
   function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                 input logic [SLOT_W-1:0] pos);
      logic [SUM_W-1:0] sum;
      sum = {1'b0, base} + {1'b0, pos};
      if (sum >= SUM_W'(DEPTH)) begin
         sum = sum - SUM_W'(DEPTH);
      end
      return sum[SLOT_W-1:0];
   endfunction

   // Window state
   logic [TEXT_W-1:0] high_ff, high_in;
   logic [TEXT_W-1:0] low_ff, low_in;
   logic [SLOT_W-1:0] base_ff, base_in;
   logic [WRAP_W-1:0] wrap_ff, wrap_in;

   // Item registers
   op_type            op_ff, op_in;
   logic [TEXT_W-1:0] num_ff, num_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   // Decoded flags and distances
   logic              below_ff, below_in;
   logic              above_ff, above_in;
   logic              inv_ff, inv_in;
   logic              del_bad_ff, del_bad_in;
   logic [TEXT_W-1:0] pos_ff, pos_in;
   logic [TEXT_W-1:0] span_ff, span_in;

   // Scan
   logic [SLOT_W-1:0] scan_pos_ff, scan_pos_in;
   logic [LEFT_W-1:0] scan_left_ff, scan_left_in;
   logic              scan_up_ff, scan_up_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [SLOT_W-1:0] rd_pos_ff, rd_pos_in;

   // Clearing pass
   logic [SLOT_W-1:0] clr_addr_ff, clr_addr_in;

   // Result and output stage
   status_type        res_status_ff, res_status_in;
   logic [TEXT_W-1:0] res_found_ff, res_found_in;
   logic [TAG_W-1:0]  res_tag_ff, res_tag_in;
   logic              out_valid_ff, out_valid_in;
   status_type        out_status_ff, out_status_in;
   logic [TEXT_W-1:0] out_found_ff, out_found_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;

   // Tag store
   logic [TAG_W-1:0]  store_mem [DEPTH];
   logic [TAG_W-1:0]  rdata_ff;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;
   logic [TAG_W-1:0]  wr_data;
   logic              wr_en;

   // Search bounds, used in the setup beat only
   logic [TEXT_W-1:0] start_pos;
   logic [TEXT_W-1:0] end_pos;
   logic              scan_empty;

   localparam logic [TEXT_W-1:0] LAST_POS = TEXT_W'(DEPTH - 1);

   // Store ports: clearing pass or set writes, access or scan reads
   always_comb begin
      rd_addr = cmd.access ? slot_of(base_ff, pos_ff[SLOT_W-1:0])
                           : slot_of(base_ff, scan_pos_ff);
      wr_en   = cmd.clr_step || (cmd.access && (op_ff == OP_SET));
      wr_addr = cmd.clr_step ? clr_addr_ff : slot_of(base_ff, pos_ff[SLOT_W-1:0]);
      wr_data = cmd.clr_step ? '0 : tag_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rdata_ff <= store_mem[rd_addr];
   end

   // Search bounds: upward runs from the clamped start to the last stored
   // position, downward from the clamped start (capped) to position zero
   always_comb begin
      if (op_ff == OP_FIND_NEXT) begin
         start_pos  = below_ff ? '0 : pos_ff;
         end_pos    = (span_ff > LAST_POS) ? LAST_POS : span_ff;
         scan_empty = inv_ff || (start_pos > end_pos);
      end else begin
         end_pos    = above_ff ? span_ff : pos_ff;
         start_pos  = (end_pos > LAST_POS) ? LAST_POS : end_pos;
         scan_empty = inv_ff || below_ff;
      end
   end

   // Next values
   always_comb begin
      high_in       = high_ff;
      low_in        = low_ff;
      base_in       = base_ff;
      wrap_in       = wrap_ff;
      op_in         = op_ff;
      num_in        = num_ff;
      tag_in        = tag_ff;
      cnt_in        = cnt_ff;
      below_in      = below_ff;
      above_in      = above_ff;
      inv_in        = inv_ff;
      del_bad_in    = del_bad_ff;
      pos_in        = pos_ff;
      span_in       = span_ff;
      scan_pos_in   = scan_pos_ff;
      scan_left_in  = scan_left_ff;
      scan_up_in    = scan_up_ff;
      rd_vld_in     = 1'b0;
      rd_pos_in     = rd_pos_ff;
      clr_addr_in   = clr_addr_ff;
      res_status_in = res_status_ff;
      res_found_in  = res_found_ff;
      res_tag_in    = res_tag_ff;
      out_status_in = out_status_ff;
      out_found_in  = out_found_ff;
      out_tag_in    = out_tag_ff;
      out_valid_in  = rsp_tready ? 1'b0 : out_valid_ff;

      // Configuration writes
      if (csr_valid) begin
         case (csr_index)
            CSR_HIGH_TEXT:   high_in = csr_data;
            CSR_INITIAL_LOW: low_in  = csr_data;
            default: ;
         endcase
      end

      // Clearing pass after reset
      if (cmd.clr_step) begin
         clr_addr_in = clr_addr_ff + SLOT_W'(1);
      end

      // Capture the request beat
      if (cmd.take_item) begin
         op_in  = op_type'(req_tuser);
         num_in = req_tdata[TEXT_W-1:0];
         tag_in = req_tdata[TAG_LSB +: TAG_W];
         cnt_in = req_tdata[CNT_LSB +: CNT_W];
      end

      // Window compares and distances
      if (cmd.decode) begin
         below_in   = num_ff < low_ff;
         above_in   = num_ff > high_ff;
         inv_in     = low_ff > high_ff;
         pos_in     = num_ff - low_ff;
         span_in    = high_ff - low_ff;
         del_bad_in = ((cnt_ff & CNT_W'(DELETE_GRANULE - 1)) != '0) ||
                      (({1'b0, high_ff} + WIDE_W'(1)) < ({1'b0, low_ff} + WIDE_W'(cnt_ff)));
      end

      // Load the scan pointer and length
      if (cmd.setup) begin
         scan_up_in   = (op_ff == OP_FIND_NEXT);
         scan_pos_in  = start_pos[SLOT_W-1:0];
         if (scan_empty) begin
            scan_left_in = '0;
         end else if (op_ff == OP_FIND_NEXT) begin
            scan_left_in = LEFT_W'(end_pos - start_pos) + LEFT_W'(1);
         end else begin
            scan_left_in = LEFT_W'(start_pos) + LEFT_W'(1);
         end
      end

      // Issue one store read per cycle while entries remain
      if (cmd.scan && (scan_left_ff != '0)) begin
         rd_vld_in    = 1'b1;
         rd_pos_in    = scan_pos_ff;
         scan_left_in = scan_left_ff - LEFT_W'(1);
         scan_pos_in  = scan_up_ff ? (scan_pos_ff + SLOT_W'(1))
                                   : (scan_pos_ff - SLOT_W'(1));
      end

      // Delete: advance low, then fold the new base into the store
      if (cmd.del_apply) begin
         low_in  = low_ff + TEXT_W'(cnt_ff);
         wrap_in = WRAP_W'(base_ff) + WRAP_W'(cnt_ff);
      end
      if (cmd.wrap_step) begin
         wrap_in = wrap_ff - WRAP_W'(DEPTH);
      end
      if (cmd.base_load) begin
         base_in = wrap_ff[SLOT_W-1:0];
      end

      // Result
      if (cmd.res_load) begin
         res_status_in = cmd.res_status;
         res_found_in  = (cmd.res_sel == RES_FOUND) ? (low_ff + TEXT_W'(rd_pos_ff)) : '0;
         res_tag_in    = (cmd.res_sel == RES_TAG) ? rdata_ff : '0;
      end

      // Output register
      if (cmd.out_load) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_found_in  = res_found_ff;
         out_tag_in    = res_tag_ff;
      end
   end

   // Control and window registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff      <= '0;
         low_ff       <= TEXT_W'(1);
         base_ff      <= '0;
         clr_addr_ff  <= '0;
         scan_left_ff <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         high_ff      <= high_in;
         low_ff       <= low_in;
         base_ff      <= base_in;
         clr_addr_ff  <= clr_addr_in;
         scan_left_ff <= scan_left_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      wrap_ff       <= wrap_in;
      op_ff         <= op_in;
      num_ff        <= num_in;
      tag_ff        <= tag_in;
      cnt_ff        <= cnt_in;
      below_ff      <= below_in;
      above_ff      <= above_in;
      inv_ff        <= inv_in;
      del_bad_ff    <= del_bad_in;
      pos_ff        <= pos_in;
      span_ff       <= span_in;
      scan_pos_ff   <= scan_pos_in;
      scan_up_ff    <= scan_up_in;
      rd_pos_ff     <= rd_pos_in;
      res_status_ff <= res_status_in;
      res_found_ff  <= res_found_in;
      res_tag_ff    <= res_tag_in;
      out_status_ff <= out_status_in;
      out_found_ff  <= out_found_in;
      out_tag_ff    <= out_tag_in;
   end

   // Status to the controller
   always_comb begin
      stat.clr_last  = (clr_addr_ff == SLOT_W'(DEPTH - 1));
      stat.op        = op_ff;
      stat.below     = below_ff;
      stat.above     = above_ff;
      stat.cap_bad   = (pos_ff >= TEXT_W'(DEPTH));
      stat.del_bad   = del_bad_ff;
      stat.scan_idle = (scan_left_ff == '0) && !rd_vld_ff;
      stat.hit       = rd_vld_ff && (rdata_ff == tag_ff);
      stat.wrap_ge   = (wrap_ff >= WRAP_W'(DEPTH));
      stat.out_free  = !out_valid_ff || rsp_tready;
   end

   // Response beat
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = RSP_DATA_W'({out_tag_ff, out_found_ff});

endmodule

// ===== sv/wtts_checker.sv =====
// Port-level checker for the windowed tag table search, bound to the top.
// Depends on wtts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wtts_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [wtts_pkg::ST_W-1:0]       rsp_tuser,
   input logic [wtts_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import wtts_pkg::*;

   // A stalled response beat holds
   `WTTS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))

   // Only defined status codes leave the block
   `WTTS_ASSERT_IMPLY(a_status_code, clock, reset, rsp_tvalid, rsp_tuser <= ST_NOT_FOUND)

   // A failed operation carries an all-zero payload
   `WTTS_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_OK), rsp_tdata == '0)

   // One item at a time: no new request straight after one is taken
   `WTTS_ASSERT_NEXT(a_one_item, clock, reset, req_tvalid && req_tready, !req_tready)

   // The clearing pass follows reset with nothing pending
   `WTTS_ASSERT_IMPLY(a_clear_busy, clock, 1'b0, $past(reset) && !reset, !req_tready && !rsp_tvalid)

endmodule

bind windowed_tag_table_search wtts_checker u_wtts_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/windowed_tag_table_search_tb.sv =====
// Testbench for the windowed tag table search block: directed and random requests
// checked beat by beat against a predictor of the tag store and its sliding window.
// Depends on wtts_pkg and windowed_tag_table_search.
`timescale 1ns / 1ps

module windowed_tag_table_search_tb;
   import wtts_pkg::*;

   localparam logic [TEXT_W-1:0] TEXT_MAX    = 31'h7FFF_FFFF;
   localparam int                CYCLE_LIMIT = 3_000_000;
   localparam int                LONG_HOLD   = 400;

   typedef struct {
      logic [OP_W-1:0]          op;
      logic [TEXT_W-1:0]        num;
      logic signed [TAG_W-1:0]  tag;
      logic [CNT_W-1:0]         cnt;
   } tag_req_t;

   typedef struct {
      logic [ST_W-1:0]          status;
      logic [TEXT_W-1:0]        found;
      logic signed [TAG_W-1:0]  tag_out;
   } tag_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [OP_W-1:0]       req_tuser = '0;     // op
   logic [REQ_DATA_W-1:0] req_tdata = '0;     // text_number, tag, delete_count, zero fill
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [ST_W-1:0]       rsp_tuser;          // status
   logic [RSP_DATA_W-1:0] rsp_tdata;          // found_number, tag_out, zero fill
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [TEXT_W-1:0]     csr_data = '0;

   windowed_tag_table_search dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block state
   logic signed [TAG_W-1:0] tag_mem [DEPTH];
   logic [TEXT_W-1:0]       win_low;
   logic [TEXT_W-1:0]       high_text_q;
   logic [SLOT_W-1:0]       base_slot_q;

   tag_req_t req_backlog[$];
   tag_rsp_t pending_responses[$];
   tag_req_t cur_req;

   int  items_queued = 0;
   int  items_accepted = 0;
   int  responses_checked = 0;
   int  csr_writes = 0;
   int  error_count = 0;
   int  req_gap = 0;
   int  rsp_wait = 0;
   int  rsp_hold = 0;
   int  hold_request = 0;
   int  hold_served = 0;
   int  cycle_count = 0;
   bit  req_calm = 1'b0;
   bit  rsp_calm = 1'b0;
   logic next_ready;
   tag_rsp_t got_rsp;
   tag_rsp_t want_rsp;

   function automatic int slot_of_pos(longint pos);
      return int'((longint'(base_slot_q) + pos) % DEPTH);
   endfunction

   function automatic int idle_cycles(bit calm);
      return calm ? 0 : $urandom_range(0, 18);
   endfunction

   // Work out the response to one request and update the shadow state
   function automatic tag_rsp_t tag_table_response(tag_req_t r);
      tag_rsp_t res;
      longint   lo, hi, num, start, last, i, left;
      bit       hit;
      int       slot;
      res.status  = ST_OK;
      res.found   = '0;
      res.tag_out = '0;
      lo  = longint'(win_low);
      hi  = longint'(high_text_q);
      num = longint'(r.num);
      hit = 1'b0;
      case (r.op)
         OP_GET, OP_SET: begin
            if (num < lo || num > hi) begin
               res.status = ST_WINDOW;
            end else if (num - lo >= DEPTH) begin
               res.status = ST_CAPACITY;
            end else begin
               slot = slot_of_pos(num - lo);
               if (r.op == OP_GET) res.tag_out = tag_mem[slot];
               else tag_mem[slot] = r.tag;
            end
         end
         OP_FIND_NEXT: begin
            start = (num < lo) ? lo : num;
            res.status = ST_NOT_FOUND;
            if (start <= hi) begin
               last = lo + DEPTH - 1;
               if (last > hi) last = hi;
               for (i = start; i <= last && !hit; i++) begin
                  if (tag_mem[slot_of_pos(i - lo)] == r.tag) begin
                     hit = 1'b1;
                     res.status = ST_OK;
                     res.found = i[TEXT_W-1:0];
                  end
               end
            end
         end
         OP_FIND_PREV: begin
            start = (num > hi) ? hi : num;
            res.status = ST_NOT_FOUND;
            if (start >= lo) begin
               last = lo + DEPTH - 1;
               if (last > start) last = start;
               for (i = last; i >= lo && !hit; i--) begin
                  if (tag_mem[slot_of_pos(i - lo)] == r.tag) begin
                     hit = 1'b1;
                     res.status = ST_OK;
                     res.found = i[TEXT_W-1:0];
                  end
               end
            end
         end
         OP_DELETE: begin
            // an inverted window has size zero or less, so only a zero count can pass there
            left = hi - lo + 1 - longint'(r.cnt);
            if ((r.cnt % DELETE_GRANULE) != 0 || left < 0) begin
               res.status = ST_BAD_DEL;
            end else begin
               win_low     = win_low + TEXT_W'(r.cnt);
               base_slot_q = SLOT_W'((longint'(base_slot_q) + longint'(r.cnt)) % DEPTH);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Request driver: predict on each accepted beat, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            pending_responses.push_back(tag_table_response(cur_req));
            items_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_tvalid <= 1'b0;
               req_gap    <= req_gap - 1;
            end else if (req_backlog.size() != 0) begin
               cur_req = req_backlog.pop_front();
               req_tuser  <= cur_req.op;
               req_tdata  <= {{(REQ_DATA_W - TEXT_W - TAG_W - CNT_W){1'b0}},
                              cur_req.cnt, cur_req.tag, cur_req.num};
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 15) == 0) req_calm = !req_calm;
               req_gap    <= idle_cycles(req_calm);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, started on request from the stimulus
   always @(posedge clock) begin
      if (reset) begin
         rsp_hold <= 0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
      end else if (hold_served != hold_request) begin
         rsp_hold    <= LONG_HOLD;
         hold_served <= hold_served + 1;
      end
   end

   // Response monitor: compare each beat with the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait   = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            responses_checked++;
            got_rsp.status  = rsp_tuser;
            got_rsp.found   = rsp_tdata[TEXT_W-1:0];
            got_rsp.tag_out = rsp_tdata[TAG_LSB +: TAG_W];
            if (pending_responses.size() == 0) begin
               if (error_count < 10)
                  $display("[%0t] response with none outstanding: status %0d found %0d tag %0d",
                           $realtime, got_rsp.status, got_rsp.found, got_rsp.tag_out);
               error_count++;
            end else begin
               want_rsp = pending_responses.pop_front();
               if (got_rsp.status !== want_rsp.status || got_rsp.found !== want_rsp.found ||
                   got_rsp.tag_out !== want_rsp.tag_out) begin
                  if (error_count < 10)
                     $display("[%0t] response %0d: status %0d/%0d found %0d/%0d tag %0d/%0d %s",
                              $realtime, responses_checked, want_rsp.status, got_rsp.status,
                              want_rsp.found, got_rsp.found, want_rsp.tag_out,
                              got_rsp.tag_out, "(expected/actual)");
                  error_count++;
               end
            end
            if ($urandom_range(0, 15) == 0) rsp_calm = !rsp_calm;
            rsp_wait = idle_cycles(rsp_calm);
         end
         if (rsp_hold != 0) begin
            next_ready = 1'b0;
         end else if (rsp_wait != 0) begin
            next_ready = 1'b0;
            rsp_wait--;
         end else begin
            next_ready = 1'b1;
         end
         rsp_tready <= next_ready;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d of %0d responses seen",
                  cycle_count, responses_checked, items_queued);
         $display("FAIL");
         $finish;
      end
   end

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [TEXT_W-1:0] num,
                            input logic [TAG_W-1:0] tag, input logic [CNT_W-1:0] cnt);
      tag_req_t r;
      r.op  = op;
      r.num = num;
      r.tag = tag;
      r.cnt = cnt;
      req_backlog.push_back(r);
      items_queued++;
   endtask

   // Register write; only issued while nothing is in flight
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TEXT_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_HIGH_TEXT) begin
         high_text_q = val;
      end else begin
         win_low    = val;
      end
      csr_writes++;
   endtask

   task automatic drain();
      while (responses_checked < items_queued) @(posedge clock);
   endtask

   // Stimulus
   initial begin
      longint lo_v, hi_v, span_v;
      int     ph, k, pick;
      logic [OP_W-1:0]         op_v;
      logic [TEXT_W-1:0]       num_v;
      logic signed [TAG_W-1:0] tag_v;
      logic [CNT_W-1:0]        cnt_v;
      logic signed [TAG_W-1:0] pool [4];

      foreach (tag_mem[i]) tag_mem[i] = '0;
      high_text_q = '0;
      win_low     = 31'd1;
      base_slot_q = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Reset window is inverted: high 0, low 1
      queue_req(OP_GET, 31'd0, 16'h0000, 13'd0);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd0);
      queue_req(OP_FIND_NEXT, 31'd0, 16'h0000, 13'd0);
      queue_req(3'd5, TEXT_MAX, 16'hFFFF, 13'h1FFF);
      queue_req(3'd7, 31'd0, 16'h0000, 13'd0);
      drain();

      // Window wider than the store: edges, capacity, clamped searches, delete
      write_reg(CSR_HIGH_TEXT, 31'd5000);
      write_reg(CSR_INITIAL_LOW, 31'd100);
      queue_req(OP_SET, 31'd100, 16'h8000, 13'd0);
      queue_req(OP_SET, 31'd4195, 16'h7FFF, 13'd0);
      queue_req(OP_SET, 31'd4196, 16'h1111, 13'd0);
      queue_req(OP_GET, 31'd99, 16'h0000, 13'd0);
      queue_req(OP_GET, 31'd5001, 16'h0000, 13'd0);
      queue_req(OP_GET, 31'd4195, 16'h0000, 13'd0);
      queue_req(OP_FIND_NEXT, 31'd0, 16'h7FFF, 13'd0);
      queue_req(OP_FIND_PREV, TEXT_MAX, 16'h8000, 13'd0);
      queue_req(OP_FIND_NEXT, 31'd101, 16'h8000, 13'd0);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd511);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'h1FFF);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd512);
      // slot freed by the delete still holds the tag of item 100
      queue_req(OP_GET, 31'd4196, 16'h0000, 13'd0);
      drain();

      // Window at the top of the number range; delete wraps low to zero
      write_reg(CSR_HIGH_TEXT, TEXT_MAX);
      write_reg(CSR_INITIAL_LOW, 31'h7FFF_FC00);
      queue_req(OP_SET, TEXT_MAX, 16'h1234, 13'd0);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd1024);
      queue_req(OP_GET, TEXT_MAX, 16'h0000, 13'd0);
      queue_req(OP_FIND_PREV, TEXT_MAX, 16'h1234, 13'd0);
      drain();

      // One-item window at zero
      write_reg(CSR_HIGH_TEXT, 31'd0);
      write_reg(CSR_INITIAL_LOW, 31'd0);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd0);
      queue_req(OP_DELETE, 31'd0, 16'h0000, 13'd512);
      queue_req(OP_SET, 31'd0, 16'hFFFF, 13'd0);
      queue_req(OP_FIND_NEXT, 31'd0, 16'hFFFF, 13'd0);
      queue_req(3'd6, 31'd0, 16'h0000, 13'd0);
      drain();

      // Random phases: fresh window each time, requests aimed at the window
      for (ph = 0; ph < 8; ph++) begin
         pick = $urandom_range(0, 3);
         case (pick)
            0: lo_v = longint'($urandom_range(0, 3000));
            1: lo_v = longint'($urandom & TEXT_MAX);
            2: lo_v = longint'(TEXT_MAX) - longint'($urandom_range(0, 2000));
            default: lo_v = longint'(win_low);
         endcase
         pick = $urandom_range(0, 9);
         if (pick == 0) span_v = -longint'($urandom_range(1, 50));
         else if (pick <= 2) span_v = longint'($urandom_range(4000, 6000));
         else span_v = longint'($urandom_range(0, 1500));
         hi_v = lo_v + span_v;
         if (hi_v < 0) hi_v = 0;
         if (hi_v > longint'(TEXT_MAX)) hi_v = longint'(TEXT_MAX);
         span_v = (hi_v >= lo_v) ? hi_v - lo_v : 10;
         write_reg(CSR_HIGH_TEXT, hi_v[TEXT_W-1:0]);
         if (lo_v != longint'(win_low) || $urandom_range(0, 1) == 0)
            write_reg(CSR_INITIAL_LOW, lo_v[TEXT_W-1:0]);
         pool[0] = TAG_W'($urandom);
         pool[1] = TAG_W'($urandom);
         pool[2] = TAG_W'($urandom);
         pool[3] = '0;
         for (k = 0; k < 14; k++) begin
            pick = $urandom_range(0, 19);
            if (pick <= 5) op_v = OP_SET;
            else if (pick <= 10) op_v = OP_GET;
            else if (pick <= 13) op_v = OP_FIND_NEXT;
            else if (pick <= 16) op_v = OP_FIND_PREV;
            else if (pick <= 18) op_v = OP_DELETE;
            else op_v = OP_W'($urandom_range(0, 7));
            if ($urandom_range(0, 9) == 0) num_v = TEXT_W'($urandom & TEXT_MAX);
            else num_v = TEXT_W'(lo_v + $urandom_range(0, int'(span_v) + 4) - 2);
            if ($urandom_range(0, 6) == 0) tag_v = TAG_W'($urandom);
            else tag_v = pool[$urandom_range(0, 3)];
            if ($urandom_range(0, 4) == 0) cnt_v = CNT_W'($urandom_range(0, 8191));
            else cnt_v = CNT_W'($urandom_range(0, 2) * DELETE_GRANULE);
            queue_req(op_v, num_v, tag_v, cnt_v);
         end
         // stall the response side for a long stretch while requests keep coming
         if (ph == 2 || ph == 6) hold_request++;
         drain();
      end

      repeat (50) @(posedge clock);
      error_count += pending_responses.size();

      $display("windowed tag table: %0d requests queued, %0d taken, %0d responses, %0d %s",
               items_queued, items_accepted, responses_checked, csr_writes,
               "register writes");
      $display("windowed tag table: %0d long response stalls, %0d errors",
               hold_served, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
